>>> src/tria_pkg.sv
// ---------------------------------------------------------------------------
// tria_pkg: shared constants for the two-resource interval assigner
// Result field widths and status codes used by the top level and its checker.
// ---------------------------------------------------------------------------
package tria_pkg;

    localparam int POS_WIDTH    = 6;
    localparam int STATUS_WIDTH = 2;

    typedef logic [STATUS_WIDTH-1:0] status_t;

    localparam status_t STATUS_ASSIGNED   = 2'd0;
    localparam status_t STATUS_IMPOSSIBLE = 2'd1;
    localparam status_t STATUS_OVERFLOW   = 2'd2;

endpackage

>>> src/two_resource_interval_assigner.sv
// ---------------------------------------------------------------------------
// two_resource_interval_assigner
// Collects a set of intervals, ranks them by start then finish, assigns each
// greedily to one of two resources and reports the assignment in input order.
// ---------------------------------------------------------------------------
// Usage: a set of n intervals is loaded at one word per cycle; the word with
// last_item high closes it, and no input is taken until every result of the
// set has been delivered. Processing runs from one single-port read memory of
// keys: each interval's sorted rank is found by comparing it against all n
// keys in turn, so the ranking pass is the longest step; it is followed by
// the greedy assignment pass and then one result word per interval, each
// of which can be held by output stall. An impossible set or a set that
// exceeded MAX_INTERVALS gives a single status word instead of per-interval
// results.
module two_resource_interval_assigner #(
    parameter int MAX_INTERVALS = 64,
    parameter int TIME_WIDTH    = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [TIME_WIDTH-1:0]                start_time,
    input  logic [TIME_WIDTH-1:0]                finish_time,
    input  logic                                 last_item,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [tria_pkg::POS_WIDTH-1:0]       position,
    output logic                                 resource,
    output logic [tria_pkg::STATUS_WIDTH-1:0]    status,
    output logic                                 last_result
);

    localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int CW = $clog2(MAX_INTERVALS + 1);
    localparam int KW = 2 * TIME_WIDTH;

    localparam logic [3:0] ST_LOAD   = 4'd0;
    localparam logic [3:0] ST_R_KEY  = 4'd1;
    localparam logic [3:0] ST_R_LAT  = 4'd2;
    localparam logic [3:0] ST_R_SCAN = 4'd3;
    localparam logic [3:0] ST_R_DONE = 4'd4;
    localparam logic [3:0] ST_A_ORD  = 4'd5;
    localparam logic [3:0] ST_A_KEY  = 4'd6;
    localparam logic [3:0] ST_A_EVAL = 4'd7;
    localparam logic [3:0] ST_O_RD   = 4'd8;
    localparam logic [3:0] ST_O_LOAD = 4'd9;
    localparam logic [3:0] ST_O_WAIT = 4'd10;

    // Memories: keys as {start, finish}, sorted order, resource bits.
    logic [KW-1:0] key_mem    [MAX_INTERVALS];
    logic [AW-1:0] order_mem  [MAX_INTERVALS];
    logic          assign_mem [MAX_INTERVALS];

    logic [3:0]            state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  ovf_reg, ovf_next;
    logic [CW-1:0]         i_reg, i_next;
    logic [CW-1:0]         j_reg, j_next;
    logic [AW-1:0]         rank_reg, rank_next;
    logic                  cmp_valid_reg, cmp_valid_next;
    logic [CW-1:0]         cmp_idx_reg, cmp_idx_next;
    logic [KW-1:0]         key_i_reg, key_i_next;
    logic [AW-1:0]         idx_reg, idx_next;
    logic [TIME_WIDTH-1:0] free0_reg, free0_next;
    logic [TIME_WIDTH-1:0] free1_reg, free1_next;
    logic                  out_valid_reg, out_valid_next;
    logic [tria_pkg::POS_WIDTH-1:0] pos_reg, pos_next;
    logic                  res_reg, res_next;
    tria_pkg::status_t     status_reg, status_next;
    logic                  out_last_reg, out_last_next;

    logic [KW-1:0]         key_rd_reg;
    logic [AW-1:0]         order_rd_reg;
    logic                  assign_rd_reg;
    logic [AW-1:0]         key_raddr;
    logic                  key_we, order_we, assign_we;
    logic                  assign_wdata;
    logic                  in_fire, out_fire, key_less;
    logic [TIME_WIDTH-1:0] cur_start, cur_finish;

    assign in_ready    = (state_reg == ST_LOAD);
    assign out_valid   = out_valid_reg;
    assign position    = pos_reg;
    assign resource    = res_reg;
    assign status      = status_reg;
    assign last_result = out_last_reg;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;

    assign cur_start  = key_rd_reg[KW-1:TIME_WIDTH];
    assign cur_finish = key_rd_reg[TIME_WIDTH-1:0];

    // Stable ordering: smaller key first, equal keys by input position.
    assign key_less = (key_rd_reg < key_i_reg)
                   || ((key_rd_reg == key_i_reg) && (cmp_idx_reg < i_reg));

    // Key memory read address.
    always_comb
    begin
        case (state_reg)
            ST_R_KEY:  key_raddr = i_reg[AW-1:0];
            ST_A_KEY:  key_raddr = order_rd_reg;
            default:   key_raddr = j_reg[AW-1:0];
        endcase
    end

    assign key_we       = in_fire && (count_reg != CW'(MAX_INTERVALS));
    assign order_we     = (state_reg == ST_R_DONE);
    assign assign_we    = (state_reg == ST_A_EVAL) && (cur_start >= free0_reg
                                                    || cur_start >= free1_reg);
    assign assign_wdata = !(cur_start >= free0_reg);

    // Memory ports, one write and one registered read each.
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[count_reg[AW-1:0]] <= {start_time, finish_time};
        end
        key_rd_reg <= key_mem[key_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (order_we)
        begin
            order_mem[rank_reg] <= i_reg[AW-1:0];
        end
        order_rd_reg <= order_mem[i_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (assign_we)
        begin
            assign_mem[idx_reg] <= assign_wdata;
        end
        assign_rd_reg <= assign_mem[i_reg[AW-1:0]];
    end

    // Sequencer: load, rank, assign, report.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        rank_next      = rank_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = j_reg;
        key_i_next     = key_i_reg;
        idx_next       = idx_reg;
        free0_next     = free0_reg;
        free1_next     = free1_reg;
        out_valid_next = out_valid_reg;
        pos_next       = pos_reg;
        res_next       = res_reg;
        status_next    = status_reg;
        out_last_next  = out_last_reg;

        // Rank accumulates one compare per cycle during the scan.
        if (cmp_valid_reg && key_less)
        begin
            rank_next = rank_reg + AW'(1);
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (key_we)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_item)
                    begin
                        if (ovf_reg || !key_we)
                        begin
                            out_valid_next = 1'b1;
                            pos_next       = '0;
                            res_next       = 1'b0;
                            status_next    = tria_pkg::STATUS_OVERFLOW;
                            out_last_next  = 1'b1;
                            state_next     = ST_O_WAIT;
                        end
                        else
                        begin
                            i_next     = '0;
                            state_next = ST_R_KEY;
                        end
                    end
                end
            end
            ST_R_KEY:
            begin
                state_next = ST_R_LAT;
            end
            ST_R_LAT:
            begin
                key_i_next = key_rd_reg;
                j_next     = '0;
                rank_next  = '0;
                state_next = ST_R_SCAN;
            end
            ST_R_SCAN:
            begin
                if (j_reg == count_reg)
                begin
                    state_next = ST_R_DONE;
                end
                else
                begin
                    cmp_valid_next = 1'b1;
                    j_next         = j_reg + CW'(1);
                end
            end
            ST_R_DONE:
            begin
                if (i_reg + CW'(1) == count_reg)
                begin
                    i_next     = '0;
                    free0_next = '0;
                    free1_next = '0;
                    state_next = ST_A_ORD;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = ST_R_KEY;
                end
            end
            ST_A_ORD:
            begin
                state_next = ST_A_KEY;
            end
            ST_A_KEY:
            begin
                idx_next   = order_rd_reg;
                state_next = ST_A_EVAL;
            end
            ST_A_EVAL:
            begin
                if (cur_start >= free0_reg)
                begin
                    free0_next = cur_finish;
                end
                else if (cur_start >= free1_reg)
                begin
                    free1_next = cur_finish;
                end
                if (!assign_we)
                begin
                    out_valid_next = 1'b1;
                    pos_next       = '0;
                    res_next       = 1'b0;
                    status_next    = tria_pkg::STATUS_IMPOSSIBLE;
                    out_last_next  = 1'b1;
                    state_next     = ST_O_WAIT;
                end
                else if (i_reg + CW'(1) == count_reg)
                begin
                    i_next     = '0;
                    state_next = ST_O_RD;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = ST_A_ORD;
                end
            end
            ST_O_RD:
            begin
                state_next = ST_O_LOAD;
            end
            ST_O_LOAD:
            begin
                out_valid_next = 1'b1;
                pos_next       = tria_pkg::POS_WIDTH'(i_reg);
                res_next       = assign_rd_reg;
                status_next    = tria_pkg::STATUS_ASSIGNED;
                out_last_next  = (i_reg + CW'(1) == count_reg);
                state_next     = ST_O_WAIT;
            end
            ST_O_WAIT:
            begin
                if (out_fire)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        i_next     = i_reg + CW'(1);
                        state_next = ST_O_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            free0_reg     <= '0;
            free1_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
            free0_reg     <= free0_next;
            free1_reg     <= free1_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        i_reg        <= i_next;
        j_reg        <= j_next;
        rank_reg     <= rank_next;
        cmp_idx_reg  <= cmp_idx_next;
        key_i_reg    <= key_i_next;
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        res_reg      <= res_next;
        status_reg   <= status_next;
        out_last_reg <= out_last_next;
    end

endmodule

>>> src/tria_checker.sv
// ---------------------------------------------------------------------------
// tria_checker: port-level checks for the interval assigner
// Watches the handshake and result framing seen at the top-level ports.
// ---------------------------------------------------------------------------
module tria_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [tria_pkg::POS_WIDTH-1:0]    position,
    input logic                              resource,
    input logic [tria_pkg::STATUS_WIDTH-1:0] status,
    input logic                              last_result
);

    // A stalled result word holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(position)
            && $stable(resource) && $stable(status) && $stable(last_result))
        else $error("result word changed while stalled");

    // The block never loads while results are pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input taken while a result is pending");

    // A status word always closes its set.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != tria_pkg::STATUS_ASSIGNED) |-> last_result)
        else $error("status word without last_result");

    // After the final word of a set, the block loads again.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_result |=> in_ready)
        else $error("block not ready after final result");

endmodule

bind two_resource_interval_assigner tria_checker u_tria_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .position    (position),
    .resource    (resource),
    .status      (status),
    .last_result (last_result)
);

>>> tb/sv/two_resource_interval_assigner_checker.sv
// ---------------------------------------------------------------------------
// two_resource_interval_assigner_checker
// Watches the interval and result channels of the assigner. It keeps its own
// copy of the current set, sorts it and assigns it greedily when the set
// closes, and compares every result word against the predicted words.
// ---------------------------------------------------------------------------
module two_resource_interval_assigner_checker #(
    parameter int MAX_INTERVALS = 64,
    parameter int TIME_WIDTH    = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [TIME_WIDTH-1:0]             start_time,
    input  logic [TIME_WIDTH-1:0]             finish_time,
    input  logic                              last_item,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [tria_pkg::POS_WIDTH-1:0]    position,
    input  logic                              resource,
    input  logic [tria_pkg::STATUS_WIDTH-1:0] status,
    input  logic                              last_result,
    output int                                fail_count,
    output int                                pending_words,
    output int                                sets_closed,
    output int                                words_seen
);

    typedef struct packed {
        logic [tria_pkg::POS_WIDTH-1:0]    pos;
        logic                              res;
        logic [tria_pkg::STATUS_WIDTH-1:0] st;
        logic                              last;
    } result_word_t;

    logic [TIME_WIDTH-1:0] set_start [MAX_INTERVALS];
    logic [TIME_WIDTH-1:0] set_finish[MAX_INTERVALS];
    int                    set_size;
    bit                    set_overflow;
    result_word_t          expected_words[$];

    // Appends one predicted word at the tail of the queue.
    function automatic void queue_word(input result_word_t w);
        expected_words = {expected_words, w};
    endfunction

    // Greedy assignment of the closed set; queues the expected words.
    task automatic close_interval_set();
        int                    order[MAX_INTERVALS];
        bit                    lane [MAX_INTERVALS];
        logic [TIME_WIDTH-1:0] free0;
        logic [TIME_WIDTH-1:0] free1;
        int                    cur;
        int                    j;
        bit                    ok;
        result_word_t          w;
        free0 = '0;
        free1 = '0;
        ok = 1;
        if (set_overflow) begin
            w = '{pos: '0, res: 1'b0, st: tria_pkg::STATUS_OVERFLOW, last: 1'b1};
            queue_word(w);
        end else begin
            // Stable insertion sort by start, then finish.
            for (int i = 0; i < set_size; i++) order[i] = i;
            for (int i = 1; i < set_size; i++) begin
                cur = order[i];
                j = i;
                while (j > 0 && (set_start[order[j-1]] > set_start[cur] ||
                       (set_start[order[j-1]] == set_start[cur] &&
                        set_finish[order[j-1]] > set_finish[cur]))) begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = cur;
            end
            for (int i = 0; i < set_size && ok; i++) begin
                cur = order[i];
                if (free0 <= set_start[cur]) begin
                    lane[cur] = 0;
                    free0 = set_finish[cur];
                end else if (free1 <= set_start[cur]) begin
                    lane[cur] = 1;
                    free1 = set_finish[cur];
                end else begin
                    ok = 0;
                end
            end
            if (!ok) begin
                w = '{pos: '0, res: 1'b0, st: tria_pkg::STATUS_IMPOSSIBLE, last: 1'b1};
                queue_word(w);
            end else begin
                for (int i = 0; i < set_size; i++) begin
                    w = '{pos: tria_pkg::POS_WIDTH'(i), res: lane[i],
                          st: tria_pkg::STATUS_ASSIGNED, last: (i == set_size - 1)};
                    queue_word(w);
                end
            end
        end
        set_size = 0;
        set_overflow = 0;
        sets_closed++;
    endtask

    // Capture input words and check result words at each rising edge.
    always @(posedge clk or negedge rst_n) begin
        result_word_t got;
        result_word_t want;
        if (!rst_n) begin
            set_size <= 0;
            set_overflow <= 0;
            fail_count <= 0;
            sets_closed <= 0;
            words_seen <= 0;
            expected_words.delete();
        end else begin
            if (out_valid && out_ready) begin
                got = '{pos: position, res: resource, st: status, last: last_result};
                words_seen++;
                if (expected_words.size() == 0) begin
                    if (fail_count < 10)
                        $display("ERROR: expected no word, got %p", got);
                    fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10)
                            $display("ERROR: expected %p, got %p", want, got);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready) begin
                if (set_size < MAX_INTERVALS) begin
                    set_start[set_size] = start_time;
                    set_finish[set_size] = finish_time;
                    set_size++;
                end else begin
                    set_overflow = 1;
                end
                if (last_item) close_interval_set();
            end
        end
        pending_words = expected_words.size();
    end

endmodule

>>> tb/sv/two_resource_interval_assigner_test.sv
// ---------------------------------------------------------------------------
// two_resource_interval_assigner_test
// Drives interval sets of many shapes into the assigner with random idle
// cycles on both channels and a long output hold-off, and reports the verdict.
// ---------------------------------------------------------------------------
module two_resource_interval_assigner_test;

    localparam int MAX_N = 64;
    localparam int TW    = 16;

    logic                              clk;
    logic                              rst_n;
    logic                              in_valid;
    logic                              in_ready;
    logic [TW-1:0]                     start_time;
    logic [TW-1:0]                     finish_time;
    logic                              last_item;
    logic                              out_valid;
    logic                              out_ready;
    logic [tria_pkg::POS_WIDTH-1:0]    position;
    logic                              resource;
    logic [tria_pkg::STATUS_WIDTH-1:0] status;
    logic                              last_result;
    int                                fail_count;
    int                                pending_words;
    int                                sets_closed;
    int                                words_seen;
    int                                words_sent;
    bit                                calm_phase;
    bit                                hold_request;

    two_resource_interval_assigner #(.MAX_INTERVALS(MAX_N), .TIME_WIDTH(TW)) u_top (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .start_time(start_time), .finish_time(finish_time), .last_item(last_item),
        .out_valid(out_valid), .out_ready(out_ready), .position(position),
        .resource(resource), .status(status), .last_result(last_result)
    );

    two_resource_interval_assigner_checker #(.MAX_INTERVALS(MAX_N), .TIME_WIDTH(TW))
        u_checker (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .start_time(start_time), .finish_time(finish_time), .last_item(last_item),
        .out_valid(out_valid), .out_ready(out_ready), .position(position),
        .resource(resource), .status(status), .last_result(last_result),
        .fail_count(fail_count), .pending_words(pending_words),
        .sets_closed(sets_closed), .words_seen(words_seen)
    );

    initial begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // Generous fixed time limit for the whole run.
    initial begin
        #4000000;
        $display("two_resource_interval_assigner_test NOT OK");
        $finish;
    end

    // Sends one word, idling at random before it; waits for acceptance.
    // Valid stays high after acceptance until the next falling edge decides
    // between a new word and an idle cycle.
    task automatic send_word(input logic [TW-1:0] s, input logic [TW-1:0] f,
                             input bit last);
        while (!calm_phase && $urandom_range(99) < 38) begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        start_time <= s;
        finish_time <= f;
        last_item <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
        @(negedge clk);
    endtask

    // A random set: small sizes mostly, times biased so both outcomes occur.
    task automatic send_random_set(input int n, input int span);
        int s;
        for (int i = 0; i < n; i++) begin
            s = $urandom_range(span);
            if ($urandom_range(19) == 0)
                send_word(TW'($urandom), TW'($urandom), i == n - 1);
            else
                send_word(TW'(s), TW'(s + 1 + $urandom_range(span / 4 + 1)),
                          i == n - 1);
        end
    endtask

    // Result side: random stalls, plus a long hold-off on request.
    initial begin
        out_ready = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_request) begin
                out_ready <= 0;
                repeat (300) @(negedge clk);
                hold_request = 0;
            end
            out_ready <= calm_phase || ($urandom_range(99) >= 38);
        end
    end

    initial begin
        in_valid = 0;
        start_time = '0;
        finish_time = '0;
        last_item = 0;
        rst_n = 0;
        words_sent = 0;
        calm_phase = 0;
        hold_request = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed sets: single interval, extremes, touching, impossible.
        send_word('0, '0, 1);
        send_word('1, '1, 1);
        send_word(16'd10, 16'd20, 0);
        send_word(16'd20, 16'd30, 0);
        send_word(16'd15, 16'd25, 1);
        send_word(16'd0, 16'd5, 0);
        send_word(16'd1, 16'd6, 0);
        send_word(16'd2, 16'd7, 1);
        send_word(16'd5, 16'd9, 0);
        send_word(16'd5, 16'd3, 0);
        send_word(16'd5, 16'd3, 0);
        send_word(16'd3, 16'd5, 1);
        send_word(16'hffff, 16'h0000, 0);
        send_word(16'h8000, 16'hffff, 0);
        send_word(16'h0000, 16'hffff, 1);
        send_word(16'h5555, 16'haaaa, 0);
        send_word(16'haaaa, 16'h5555, 1);

        // Capacity overflow: 65 intervals, the receiver held off meanwhile.
        hold_request = 1;
        for (int i = 0; i < MAX_N + 1; i++)
            send_word(TW'(i * 3), TW'(i * 3 + 2), i == MAX_N);

        // A full set of 64 touching intervals, sent without idling.
        calm_phase = 1;
        for (int i = 0; i < MAX_N; i++)
            send_word(TW'(i * 7), TW'(i * 7 + 7), i == MAX_N - 1);
        calm_phase = 0;

        // Random sets until about 270 words have gone in.
        while (words_sent < 270) begin
            calm_phase = ($urandom_range(9) == 0);
            send_random_set($urandom_range(1, 8), $urandom_range(1, 3) * 40);
        end
        calm_phase = 0;
        in_valid <= 0;

        while (pending_words != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        $display("Covered %0d interval words in %0d sets, %0d result words checked.",
                 words_sent, sets_closed, words_seen);
        if (fail_count == 0)
            $display("two_resource_interval_assigner_test OK");
        else
            $display("two_resource_interval_assigner_test NOT OK");
        $finish;
    end

endmodule
